// File: hw/rtl/gradient_noise_2d_3d_assert.svh
// assertion macros for the gradient noise block
`ifndef GRADIENT_NOISE_2D_3D_ASSERT_SVH
`define GRADIENT_NOISE_2D_3D_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GN_ASSERT_NOW(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("gradient noise check failed");

// next-cycle implication, checked outside reset
`define GN_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("gradient noise check failed");

`endif

// File: hw/rtl/gn_pkg.sv
// shared types, constants and fixed-point helpers for the gradient noise block
package gn_pkg;
	localparam logic [1:0] CMD_EVAL   = 2'd0;
	localparam logic [1:0] CMD_HASH   = 2'd1;
	localparam logic [1:0] CMD_GRAD   = 2'd2;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int FRAC_W = 16;
	localparam int GRAD_W = 16;
	localparam int HASH_W = 8;
	localparam int W_W    = 17;
	localparam int OFF_W  = 18;
	localparam int DOT_W  = 36;
	localparam int DIFF_W = 37;
	localparam int PROD_W = 55;
	localparam int OUT_W  = 18;

	localparam logic [17:0] SMOOTH_K = 18'd196608;

	typedef logic [FRAC_W-1:0]        frac_t;
	typedef logic [W_W-1:0]           weight_t;
	typedef logic signed [DOT_W-1:0]  dot_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic [3*GRAD_W-1:0]      gvec_t;
	typedef logic signed [OUT_W-1:0]  noise_t;

	typedef struct packed {
		logic valid;
		logic three;
	} ctl_t;

	localparam dot_t SAT_HI = 36'sd131071;
	localparam dot_t SAT_LO = -36'sd131072;

	function automatic prod_t lerp_mul(dot_t a, dot_t b, weight_t w);
		logic signed [DIFF_W-1:0] d;
		logic signed [W_W:0]      ws;
		d  = DIFF_W'(b) - DIFF_W'(a);
		ws = $signed({1'b0, w});
		return PROD_W'(d) * PROD_W'(ws);
	endfunction

	function automatic dot_t lerp_add(dot_t a, prod_t p);
		prod_t r;
		r = (p + PROD_W'(32768)) >>> 16;
		return a + DOT_W'(r);
	endfunction

	function automatic noise_t out_sat(dot_t r);
		dot_t q;
		q = (r + DOT_W'(16384)) >>> 15;
		if (q > SAT_HI) begin
			q = SAT_HI;
		end else if (q < SAT_LO) begin
			q = SAT_LO;
		end
		return OUT_W'(q);
	endfunction
endpackage

// File: hw/rtl/gn_weight.sv
// smoothstep weight pipeline, 3t^2-2t^3 rounded to q0.16
module gn_weight (
	input  logic             clk,
	input  logic             en,
	input  gn_pkg::frac_t    t [3],
	output gn_pkg::weight_t  w_s5 [3]
);
	logic [31:0]     t2_s1 [3];
	gn_pkg::frac_t   t_s1 [3];
	logic [49:0]     s_s2 [3];
	gn_pkg::weight_t w_s3 [3];
	gn_pkg::weight_t w_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				t2_s1[k] <= t[k] * t[k];
				t_s1[k]  <= t[k];
				s_s2[k]  <= 50'(t2_s1[k])
					* 50'(gn_pkg::SMOOTH_K - {1'b0, t_s1[k], 1'b0});
				w_s3[k]  <= gn_pkg::W_W'((s_s2[k] + 50'(33'h080000000)) >> 32);
				w_s4[k]  <= w_s3[k];
				w_s5[k]  <= w_s4[k];
			end
		end
	end
endmodule

// File: hw/rtl/gn_lattice.sv
// lattice hash chain and gradient lookup, replicated tables, four stages
module gn_lattice #(
	parameter int TABLE_SIZE = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                acc,
	input  logic                three,
	input  logic [1:0]          command,
	input  logic signed [31:0]  coord_x,
	input  logic signed [31:0]  coord_y,
	input  logic signed [31:0]  coord_z,
	input  logic [7:0]          table_index,
	input  logic [7:0]          hash_value,
	input  gn_pkg::gvec_t       grad_in,
	output gn_pkg::ctl_t        ctl_s4,
	output gn_pkg::frac_t       frac_s4 [3],
	output gn_pkg::gvec_t       grad_s4 [8]
);
	localparam int IW = $clog2(TABLE_SIZE);

	logic [7:0]           m1 [TABLE_SIZE];
	logic [7:0]           m2 [2][TABLE_SIZE];
	logic [7:0]           m3 [4][TABLE_SIZE];
	gn_pkg::gvec_t        mg [4][TABLE_SIZE];

	logic                 v_s1, v_s2, v_s3;
	logic [1:0]           cmd_s1, cmd_s2, cmd_s3;
	logic                 three_s1, three_s2, three_s3, three_s4;
	logic [IW-1:0]        bx_s1, bx_s2, by_s1;
	gn_pkg::frac_t        frac_s1 [3];
	gn_pkg::frac_t        frac_s2 [3];
	gn_pkg::frac_t        frac_s3 [3];
	logic [IW-1:0]        widx_s1, widx_s2, widx_s3;
	logic [7:0]           hv_s1, hv_s2;
	gn_pkg::gvec_t        gw_s1, gw_s2, gw_s3;
	logic [7:0]           h1_s1 [2];
	logic [7:0]           h2_s2 [4];
	logic [7:0]           h3_s3 [8];
	logic                 ev_s4;

	logic [IW-1:0]        bz;
	logic [IW-1:0]        widx_in;

	assign bz      = coord_z[16 +: IW];
	assign widx_in = IW'(table_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			ev_s4 <= 1'b0;
		end else if (en) begin
			v_s1  <= acc;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			ev_s4 <= v_s3 && (cmd_s3 == gn_pkg::CMD_EVAL);
		end
	end

	// stage 1: split coordinates, first hash level
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s1     <= command;
			three_s1   <= three;
			bx_s1      <= coord_x[16 +: IW];
			by_s1      <= coord_y[16 +: IW];
			frac_s1[0] <= coord_x[15:0];
			frac_s1[1] <= coord_y[15:0];
			frac_s1[2] <= coord_z[15:0];
			widx_s1    <= widx_in;
			hv_s1      <= hash_value;
			gw_s1      <= grad_in;
			for (int c = 0; c < 2; c++) begin
				h1_s1[c] <= m1[bz + IW'(c)];
			end
			if (acc && (command == gn_pkg::CMD_HASH)) begin
				m1[widx_in] <= hash_value;
			end
		end
	end

	// stage 2: second hash level
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2   <= cmd_s1;
			three_s2 <= three_s1;
			bx_s2    <= bx_s1;
			frac_s2  <= frac_s1;
			widx_s2  <= widx_s1;
			hv_s2    <= hv_s1;
			gw_s2    <= gw_s1;
			for (int c = 0; c < 2; c++) begin
				for (int b = 0; b < 2; b++) begin
					h2_s2[c*2+b] <= m2[c][by_s1 + IW'(b)
						+ (three_s1 ? IW'(h1_s1[c]) : IW'(0))];
				end
				if (v_s1 && (cmd_s1 == gn_pkg::CMD_HASH)) begin
					m2[c][widx_s1] <= hv_s1;
				end
			end
		end
	end

	// stage 3: third hash level
	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s3   <= cmd_s2;
			three_s3 <= three_s2;
			frac_s3  <= frac_s2;
			widx_s3  <= widx_s2;
			gw_s3    <= gw_s2;
			for (int j = 0; j < 4; j++) begin
				for (int a = 0; a < 2; a++) begin
					h3_s3[j*2+a] <= m3[j][bx_s2 + IW'(a) + IW'(h2_s2[j])];
				end
				if (v_s2 && (cmd_s2 == gn_pkg::CMD_HASH)) begin
					m3[j][widx_s2] <= hv_s2;
				end
			end
		end
	end

	// stage 4: gradient lookup
	always_ff @(posedge clk) begin
		if (en) begin
			three_s4 <= three_s3;
			frac_s4  <= frac_s3;
			for (int j = 0; j < 4; j++) begin
				for (int a = 0; a < 2; a++) begin
					grad_s4[j*2+a] <= mg[j][IW'(h3_s3[j*2+a])];
				end
				if (v_s3 && (cmd_s3 == gn_pkg::CMD_GRAD)) begin
					mg[j][widx_s3] <= gw_s3;
				end
			end
		end
	end

	assign ctl_s4.valid = ev_s4;
	assign ctl_s4.three = three_s4;
endmodule

// File: hw/rtl/gn_blend.sv
// corner dot products, trilinear blend and output rounding
module gn_blend (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  gn_pkg::ctl_t      ctl_s4,
	input  gn_pkg::frac_t     frac_s4 [3],
	input  gn_pkg::gvec_t     grad_s4 [8],
	input  gn_pkg::weight_t   w_s5 [3],
	output logic              valid_s12,
	output gn_pkg::noise_t    noise_s12
);
	gn_pkg::ctl_t    ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9, ctl_s10, ctl_s11;
	gn_pkg::dot_t    dot_s5 [8];
	gn_pkg::prod_t   p_s6 [4];
	gn_pkg::dot_t    a_s6 [4];
	gn_pkg::weight_t w1_s6, w1_s7, w2_s6, w2_s7, w2_s8, w2_s9;
	gn_pkg::dot_t    y_s7 [4];
	gn_pkg::prod_t   p_s8 [2];
	gn_pkg::dot_t    a_s8 [2];
	gn_pkg::dot_t    z_s9 [2];
	gn_pkg::prod_t   p_s10;
	gn_pkg::dot_t    a_s10;
	gn_pkg::dot_t    r_s11;

	logic signed [gn_pkg::OFF_W-1:0]  off [8][3];
	logic signed [gn_pkg::GRAD_W-1:0] g   [8][3];
	gn_pkg::dot_t                     dot [8];

	always_comb begin
		for (int k = 0; k < 8; k++) begin
			for (int d = 0; d < 3; d++) begin
				off[k][d] = $signed({2'b00, frac_s4[d]})
					- (k[d] ? 18'sd65536 : 18'sd0);
				g[k][d] = $signed(grad_s4[k][d*gn_pkg::GRAD_W +: gn_pkg::GRAD_W]);
			end
			dot[k] = gn_pkg::DOT_W'(g[k][0]) * gn_pkg::DOT_W'(off[k][0])
				+ gn_pkg::DOT_W'(g[k][1]) * gn_pkg::DOT_W'(off[k][1])
				+ (ctl_s4.three ? gn_pkg::DOT_W'(g[k][2]) * gn_pkg::DOT_W'(off[k][2])
					: gn_pkg::DOT_W'(0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5    <= '0;
			ctl_s6    <= '0;
			ctl_s7    <= '0;
			ctl_s8    <= '0;
			ctl_s9    <= '0;
			ctl_s10   <= '0;
			ctl_s11   <= '0;
			valid_s12 <= 1'b0;
		end else if (en) begin
			ctl_s5    <= ctl_s4;
			ctl_s6    <= ctl_s5;
			ctl_s7    <= ctl_s6;
			ctl_s8    <= ctl_s7;
			ctl_s9    <= ctl_s8;
			ctl_s10   <= ctl_s9;
			ctl_s11   <= ctl_s10;
			valid_s12 <= ctl_s11.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s5 <= dot;
			// x blend
			for (int j = 0; j < 4; j++) begin
				p_s6[j] <= gn_pkg::lerp_mul(dot_s5[j*2], dot_s5[j*2+1], w_s5[0]);
				a_s6[j] <= dot_s5[j*2];
				y_s7[j] <= gn_pkg::lerp_add(a_s6[j], p_s6[j]);
			end
			w1_s6 <= w_s5[1];
			w1_s7 <= w1_s6;
			w2_s6 <= w_s5[2];
			w2_s7 <= w2_s6;
			w2_s8 <= w2_s7;
			w2_s9 <= w2_s8;
			// y blend
			for (int c = 0; c < 2; c++) begin
				p_s8[c] <= gn_pkg::lerp_mul(y_s7[c*2], y_s7[c*2+1], w1_s7);
				a_s8[c] <= y_s7[c*2];
				z_s9[c] <= gn_pkg::lerp_add(a_s8[c], p_s8[c]);
			end
			// z blend
			p_s10     <= gn_pkg::lerp_mul(z_s9[0], z_s9[1], w2_s9);
			a_s10     <= z_s9[0];
			r_s11     <= ctl_s10.three ? gn_pkg::lerp_add(a_s10, p_s10) : a_s10;
			noise_s12 <= gn_pkg::out_sat(r_s11);
		end
	end
endmodule

// File: hw/rtl/gradient_noise_2d_3d.sv
// Lattice gradient noise, 2D or 3D, in fixed point. Every command word moves through a
// twelve-stage pipeline and one word is taken each cycle while the output side keeps up;
// an evaluate shows its noise word on the output once it has passed the lattice stages
// and then the blend stages, and table writes return nothing. The hash and gradient
// tables are replicated so that each copy serves at most two of the corner lookups of
// a stage, and a table write reaches each copy in the stage that reads it, so reads and
// writes keep command order. The whole pipeline holds while a finished word waits under
// stall. Every table entry must be written before an evaluate reads it.
module gradient_noise_2d_3d #(
	parameter int TABLE_SIZE = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         command,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic signed [31:0] coord_z,
	input  logic [7:0]         table_index,
	input  logic [7:0]         hash_value,
	input  logic signed [15:0] grad_x,
	input  logic signed [15:0] grad_y,
	input  logic signed [15:0] grad_z,
	output logic               res_valid,
	input  logic               res_stall,
	output logic signed [17:0] noise_value
);
	logic               three_q;
	logic               en;
	logic               acc;
	gn_pkg::ctl_t       ctl_s4;
	gn_pkg::frac_t      frac_s4 [3];
	gn_pkg::gvec_t      grad_s4 [8];
	gn_pkg::weight_t    w_s5 [3];
	gn_pkg::frac_t      t_in [3];

	assign en        = !(res_valid && res_stall);
	assign cmd_stall = !en;
	assign acc       = cmd_valid && en;

	assign t_in[0] = coord_x[15:0];
	assign t_in[1] = coord_y[15:0];
	assign t_in[2] = coord_z[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			three_q <= 1'b1;
		end else if (cfg_we) begin
			three_q <= cfg_wdata;
		end
	end

	gn_lattice #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_lattice (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.acc         (acc),
		.three       (three_q),
		.command     (command),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.coord_z     (coord_z),
		.table_index (table_index),
		.hash_value  (hash_value),
		.grad_in     ({grad_z, grad_y, grad_x}),
		.ctl_s4      (ctl_s4),
		.frac_s4     (frac_s4),
		.grad_s4     (grad_s4)
	);

	gn_weight u_weight (
		.clk  (clk),
		.en   (en),
		.t    (t_in),
		.w_s5 (w_s5)
	);

	gn_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.ctl_s4    (ctl_s4),
		.frac_s4   (frac_s4),
		.grad_s4   (grad_s4),
		.w_s5      (w_s5),
		.valid_s12 (res_valid),
		.noise_s12 (noise_value)
	);
endmodule

// File: hw/rtl/gn_checker.sv
// port-level checks for the gradient noise block and their binding
`include "gradient_noise_2d_3d_assert.svh"

module gn_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_stall,
	input logic               res_valid,
	input logic               res_stall,
	input logic signed [17:0] noise_value
);
	// input holds only behind a blocked result word
	`GN_ASSERT_NOW(a_stall_cause, clk, arst_n, cmd_stall, res_valid && res_stall)
	`GN_ASSERT_NOW(a_no_idle_stall, clk, arst_n, !res_valid || !res_stall, !cmd_stall)
	// blocked result word holds
	`GN_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(noise_value))
endmodule

bind gradient_noise_2d_3d gn_checker u_gn_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_stall   (cmd_stall),
	.res_valid   (res_valid),
	.res_stall   (res_stall),
	.noise_value (noise_value)
);
